/* rtl/core/sacl_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
package sacl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned TOTAL_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_INSN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage

/* rtl/core/sacl_ctrl.sv */
// Controller: clearing pass, item sequencing and output register handshake.
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    out_valid_d = cmd_o.finish || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_EXEC)
    else $error("accepted item did not enter execution");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished item not presented");

  a_clear_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clear_done) |=> state_q == ST_IDLE)
    else $error("clearing pass did not end");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !in_ready_o)
    else $error("item accepted while one is in execution");

endmodule

/* rtl/core/sacl_dp.sv */
// Datapath: config registers, set memory, lookup, LRU update and running totals.
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [1:0]             in_op_i,
  input  logic [ADDR_WIDTH-1:0]  in_addr_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned SW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned NUM_ROWS = 1 << SW;
  localparam int unsigned RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WW       = RW;
  localparam int unsigned NW       = $clog2(MAX_WAYS + 1);
  localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [RW-1:0]         rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  row_t mem_q [NUM_ROWS];
  row_t rd_row_q;
  row_t new_row;

  logic [2:0]            set_bits_q;
  logic [5:0]            block_bits_q;
  logic [3:0]            ways_q;
  logic [SW-1:0]         clr_cnt_q;
  logic [SW-1:0]         set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  op_e                   op_q;
  logic [TOTAL_W-1:0]    hits_q, misses_q, evicts_q;
  logic [TOTAL_W-1:0]    hits_d, misses_d, evicts_d;
  logic [1:0]            hc_q;
  logic                  missed_q, evicted_q;

  logic [3:0]            s_eff;
  logic [6:0]            sb;
  logic [SW-1:0]         set_mask;
  logic [ADDR_WIDTH-1:0] addr_sh;
  logic [SW-1:0]         set_in;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [NW-1:0]         n_ways;

  logic [MAX_WAYS-1:0]   act, match, free, is_max;
  logic [WW-1:0]         hit_way, free_way, vict_way, tgt_way;
  logic                  hit, free_any;
  logic [RW-1:0]         r_ref;
  logic [1:0]            hc;
  logic                  do_write;
  logic [TOTAL_W:0]      hit_sum;

  // Address split at accept
  always_comb begin
    s_eff = (4'(set_bits_q) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits_q);
    sb    = 7'(s_eff) + 7'(block_bits_q);
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = int'(s_eff) > i;
    end
    addr_sh = in_addr_i >> block_bits_q;
    set_in  = addr_sh[SW-1:0] & set_mask;
    tag_in  = in_addr_i >> sb;
  end

  always_comb begin
    if (ways_q == 4'd0) begin
      n_ways = NW'(1);
    end else if (5'(ways_q) > 5'(MAX_WAYS)) begin
      n_ways = NW'(MAX_WAYS);
    end else begin
      n_ways = NW'(ways_q);
    end
  end

  // Lookup and LRU update on the read row
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      act[w]   = NW'(w) < n_ways;
      match[w] = act[w] && rd_row_q[w].valid && (rd_row_q[w].tag == tag_q);
      free[w]  = act[w] && !rd_row_q[w].valid;
      is_max[w] = act[w];
      for (int u = 0; u < MAX_WAYS; u++) begin
        if (act[u] && u < w && rd_row_q[u].rank >= rd_row_q[w].rank) begin
          is_max[w] = 1'b0;
        end
        if (act[u] && u > w && rd_row_q[u].rank > rd_row_q[w].rank) begin
          is_max[w] = 1'b0;
        end
      end
    end
    hit_way  = '0;
    free_way = '0;
    vict_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WW'(w);
      end
      if (free[w]) begin
        free_way = WW'(w);
      end
      if (is_max[w]) begin
        vict_way = WW'(w);
      end
    end
    hit      = |match;
    free_any = |free;
    tgt_way  = hit ? hit_way : (free_any ? free_way : vict_way);
    r_ref    = rd_row_q[tgt_way].rank;

    new_row = rd_row_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (act[w] && rd_row_q[w].valid && (WW'(w) != tgt_way) &&
          ((!hit && free_any) || rd_row_q[w].rank < r_ref) &&
          rd_row_q[w].rank < RANK_MAX) begin
        new_row[w].rank = rd_row_q[w].rank + RW'(1);
      end
    end
    new_row[tgt_way].valid = 1'b1;
    new_row[tgt_way].tag   = tag_q;
    new_row[tgt_way].rank  = '0;

    do_write = cmd_i.finish && (op_q != OP_INSN);
    hc = '0;
    if (op_q != OP_INSN) begin
      hc = {1'b0, hit} + {1'b0, op_q == OP_MODIFY};
    end
  end

  // Saturating totals
  always_comb begin
    hit_sum  = {1'b0, hits_q} + (TOTAL_W + 1)'(hc);
    hits_d   = hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (op_q != OP_INSN && !hit && !(&misses_q)) begin
      misses_d = misses_q + 1'b1;
    end
    if (op_q != OP_INSN && !hit && !free_any && !(&evicts_q)) begin
      evicts_d = evicts_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= 4'd1;
      clr_cnt_q    <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
          CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
          CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.finish) begin
        hits_q   <= hits_d;
        misses_q <= misses_d;
        evicts_q <= evicts_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (do_write) begin
      mem_q[set_q] <= new_row;
    end
    if (cmd_i.accept) begin
      rd_row_q <= mem_q[set_in];
      set_q    <= set_in;
      tag_q    <= tag_in;
      op_q     <= op_e'(in_op_i);
    end
    if (cmd_i.finish) begin
      hc_q      <= hc;
      missed_q  <= (op_q != OP_INSN) && !hit;
      evicted_q <= (op_q != OP_INSN) && !hit && !free_any;
    end
  end

  assign sts_o.clear_done = &clr_cnt_q;

  // tdata: hit_count, missed, evicted, total_hits, total_misses, total_evictions
  assign out_data_o = {4'b0, evicts_q, misses_q, hits_q, evicted_q, missed_q, hc_q};

  a_hits_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hits_q >= $past(hits_q))
    else $error("hit total decreased");

  a_miss_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && evicts_d != evicts_q) |-> (misses_d != misses_q || &misses_q))
    else $error("eviction counted without a miss");

endmodule

/* rtl/core/set_assoc_cache_lru_sim.sv */
// Top level of the set-associative LRU cache model.
//
// Input channel s_axis carries one access per item: op and byte address.
// Output channel m_axis carries one result per item: hit count, miss and
// eviction flags, and the three saturating running totals.
// The cfg port writes set_bits (index 0), block_bits (1) and ways (2) on any
// cycle with cfg_we_i high; write only while no item is in flight.
// Each item's set row is read into a register on accept, in IDLE; in EXEC come
// the parallel tag compare, LRU update and row write-back, which share the
// single port of the set memory. A new item is accepted only from IDLE, once the
// last one has left EXEC. After reset the set memory is cleared one row per
// cycle, all 2**MAX_SET_BITS rows (64 by default), before s_axis_tready rises.
// A result waits in the output register until taken; a further item is then
// accepted but held in EXEC while the receiver stalls.
module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op, address
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit_count, missed, evicted,
                                                 // total_hits, total_misses,
                                                 // total_evictions
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sacl_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (s_axis_tdata[1:0]),
    .in_addr_i  (s_axis_tdata[ADDR_WIDTH+1:2]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule

/* verif/tb_set_assoc_cache_lru_sim.sv */
// Self-checking testbench for set_assoc_cache_lru_sim against an LRU cache predictor.
module tb_set_assoc_cache_lru_sim
  import sacl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CACHE_SET_BITS = 6;
  localparam int unsigned CACHE_WAYS     = 8;
  localparam int unsigned CACHE_LINES    = (1 << CACHE_SET_BITS) * CACHE_WAYS;
  localparam int unsigned LONG_STALL_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS    = 130;

  typedef struct packed {
    logic [1:0]  hit_count;
    logic        missed;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } access_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // op, address
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // hit_count, missed, evicted, total_hits,
                                               // total_misses, total_evictions

  set_assoc_cache_lru_sim dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic              lru_valid [CACHE_LINES];
  logic [63:0]       lru_tag   [CACHE_LINES];
  logic [2:0]        lru_rank  [CACHE_LINES];
  logic [31:0]       hit_total, miss_total, evict_total;
  int unsigned       geo_set_bits, geo_block_bits, geo_ways;

  access_result_t    access_results_q[$];
  int unsigned       items_sent, results_seen, mismatch_count, cfg_writes, long_stalls_done;
  bit                idle_en = 1'b1;
  bit                long_stall_req = 1'b0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void bump_rank(int unsigned i);
    if (lru_rank[i] < CACHE_WAYS - 1) lru_rank[i] = lru_rank[i] + 3'd1;
  endfunction

  function automatic void cache_access(input logic [63:0] addr, output logic hit,
                                       output logic ev);
    int unsigned s, b, n, row, base, hitw, freew, vict, w;
    logic [63:0] tag;
    logic [2:0]  r;
    s = (geo_set_bits > CACHE_SET_BITS) ? CACHE_SET_BITS : geo_set_bits;
    b = geo_block_bits;
    n = (geo_ways == 0) ? 1 : ((geo_ways > CACHE_WAYS) ? CACHE_WAYS : geo_ways);
    tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
    row = 32'((addr >> b) & ((64'd1 << s) - 64'd1));
    base = row * CACHE_WAYS;
    hitw = n;
    freew = n;
    vict = 0;
    hit = 1'b0;
    ev = 1'b0;
    for (w = 0; w < n; w++) begin
      if (lru_valid[base + w]) begin
        if (hitw == n && lru_tag[base + w] == tag) hitw = w;
      end else if (freew == n) begin
        freew = w;
      end
    end
    if (hitw < n) begin
      r = lru_rank[base + hitw];
      for (w = 0; w < n; w++)
        if (w != hitw && lru_valid[base + w] && lru_rank[base + w] < r) bump_rank(base + w);
      lru_rank[base + hitw] = '0;
      hit = 1'b1;
    end else if (freew < n) begin
      for (w = 0; w < n; w++)
        if (lru_valid[base + w]) bump_rank(base + w);
      lru_valid[base + freew] = 1'b1;
      lru_tag[base + freew] = tag;
      lru_rank[base + freew] = '0;
    end else begin
      // set full: oldest way goes, lowest index on a rank tie
      for (w = 1; w < n; w++)
        if (lru_rank[base + w] > lru_rank[base + vict]) vict = w;
      r = lru_rank[base + vict];
      for (w = 0; w < n; w++)
        if (w != vict && lru_rank[base + w] < r) bump_rank(base + w);
      lru_tag[base + vict] = tag;
      lru_rank[base + vict] = '0;
      ev = 1'b1;
    end
  endfunction

  function automatic access_result_t predict_access(op_e op, logic [63:0] addr);
    access_result_t res;
    logic hit, ev;
    res = '0;
    if (op != OP_INSN) begin
      cache_access(addr, hit, ev);
      if (hit) begin
        res.hit_count = 2'd1;
      end else begin
        res.missed = 1'b1;
        miss_total = sat_inc(miss_total);
        if (ev) begin
          res.evicted = 1'b1;
          evict_total = sat_inc(evict_total);
        end
      end
      if (op == OP_MODIFY) res.hit_count = res.hit_count + 2'd1;
      if (res.hit_count >= 2'd1) hit_total = sat_inc(hit_total);
      if (res.hit_count == 2'd2) hit_total = sat_inc(hit_total);
    end
    res.total_hits = hit_total;
    res.total_misses = miss_total;
    res.total_evictions = evict_total;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_access(input op_e op, input logic [63:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - 66){1'b0}}, addr, op};
    do @(posedge clk_i); while (!s_axis_tready);
    access_results_q.push_back(predict_access(op, addr));
    items_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_SET_BITS:   geo_set_bits = value & 7;
      CFG_BLOCK_BITS: geo_block_bits = value & 63;
      CFG_WAYS:       geo_ways = value & 15;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned sb, input int unsigned bb, input int unsigned w);
    write_cfg(CFG_SET_BITS, sb);
    write_cfg(CFG_BLOCK_BITS, bb);
    write_cfg(CFG_WAYS, w);
  endtask

  // reset geometry: one set, byte blocks, one way
  task automatic test_cold_and_repeat();
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_STORE, '1);
    send_access(OP_MODIFY, '1);
    send_access(OP_INSN, 64'h1234);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
    send_access(OP_STORE, 64'd0);
  endtask

  // out-of-range registers and tag shifts of 64 or more
  task automatic test_field_extremes();
    set_geometry(7, 63, 15);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, '1);
    send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    set_geometry(6, 58, 8);
    send_access(OP_STORE, '1);
    send_access(OP_LOAD, 64'hFC00_0000_0000_0000);
    send_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
    set_geometry(0, 0, 0);
    send_access(OP_LOAD, 64'h5555_5555_5555_5555);
    send_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // shrinking the way count leaves two ways with one tag, then a rank tie
  task automatic test_duplicate_tags();
    set_geometry(0, 0, 2);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, 64'd1);
    write_cfg(CFG_WAYS, 1);
    send_access(OP_LOAD, 64'd1);
    write_cfg(CFG_WAYS, 2);
    send_access(OP_LOAD, 64'd1);
    send_access(OP_STORE, 64'd2);
  endtask

  task automatic test_lru_order();
    int unsigned seq [8] = '{1, 2, 3, 4, 1, 5, 2, 1};
    int unsigned i;
    set_geometry(2, 4, 4);
    for (i = 0; i < 8; i++)
      send_access(OP_LOAD, (64'(seq[i]) << 6) | 64'h1_5);
  endtask

  task automatic test_random_phases();
    logic [63:0] line_pool [40];
    logic [63:0] addr, offset_mask;
    int unsigned phase, pool_size, i, k, sb, bb, w;
    for (phase = 0; phase < 11; phase++) begin
      case (phase)
        0: begin sb = 0; bb = 0; w = 1; end
        1: begin sb = 6; bb = 58; w = 8; end
        2: begin sb = 7; bb = 63; w = 15; end
        3: begin sb = 2; bb = 4; w = 0; end
        4: begin sb = 0; bb = 3; w = 8; end
        default: begin
          sb = $urandom_range(0, 7);
          bb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10);
          w = $urandom_range(0, 15);
        end
      endcase
      set_geometry(sb, bb, w);
      idle_en = (phase != 5);
      offset_mask = (64'd1 << geo_block_bits) - 64'd1;
      pool_size = $urandom_range(2, 40);
      for (i = 0; i < pool_size; i++) line_pool[i] = {$urandom, $urandom};
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          addr = {$urandom, $urandom};
        end else begin
          addr = line_pool[$urandom_range(0, pool_size - 1)];
          addr = addr ^ ({$urandom, $urandom} & offset_mask);
        end
        send_access(op_e'($urandom_range(0, 3)), addr);
      end
    end
    idle_en = 1'b1;
  endtask

  // output held off long enough that the input side backs up
  task automatic test_full_backpressure();
    int unsigned k;
    set_geometry(1, 2, 3);
    idle_en = 1'b0;
    long_stall_req = 1'b1;
    for (k = 0; k < 40; k++)
      send_access(op_e'($urandom_range(0, 3)), 64'($urandom_range(0, 63)));
    idle_en = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = LONG_STALL_CYCLES;
        long_stalls_done++;
      end else if (stall_left == 0 && m_axis_tready) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    access_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit_count       = m_axis_tdata[1:0];
      got.missed          = m_axis_tdata[2];
      got.evicted         = m_axis_tdata[3];
      got.total_hits      = m_axis_tdata[35:4];
      got.total_misses    = m_axis_tdata[67:36];
      got.total_evictions = m_axis_tdata[99:68];
      results_seen++;
      if (access_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item: %h", m_axis_tdata);
      end else begin
        want = access_results_q.pop_front();
        if (got.hit_count !== want.hit_count || got.missed !== want.missed ||
            got.evicted !== want.evicted || got.total_hits !== want.total_hits ||
            got.total_misses !== want.total_misses ||
            got.total_evictions !== want.total_evictions) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected hc=%0d miss=%0b ev=%0b hits=%0d misses=%0d evicts=%0d",
                     want.hit_count, want.missed, want.evicted, want.total_hits,
                     want.total_misses, want.total_evictions);
            $display("  actual   hc=%0d miss=%0b ev=%0b hits=%0d misses=%0d evicts=%0d",
                     got.hit_count, got.missed, got.evicted, got.total_hits,
                     got.total_misses, got.total_evictions);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < CACHE_LINES; i++) begin
      lru_valid[i] = 1'b0;
      lru_tag[i] = '0;
      lru_rank[i] = '0;
    end
    hit_total = '0;
    miss_total = '0;
    evict_total = '0;
    geo_set_bits = 0;
    geo_block_bits = 0;
    geo_ways = 1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cold_and_repeat();
    test_field_extremes();
    test_duplicate_tags();
    test_lru_order();
    test_random_phases();
    test_full_backpressure();

    settle();
    repeat (10) @(posedge clk_i);
    $display("checked %0d results from %0d accesses across %0d register writes",
             results_seen, items_sent, cfg_writes);
    $display("predicted totals: %0d hits, %0d misses, %0d evictions; %0d long output stalls",
             hit_total, miss_total, evict_total, long_stalls_done);
    if (mismatch_count == 0 && access_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
